// ===== rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the sbus frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int NUM_CH        = 16;
    localparam int CH_W          = 11;
    localparam int PAYLOAD_BYTES = 23;
    localparam int DATA_W        = 176;
    localparam int STORE_W       = PAYLOAD_BYTES * 8;

    localparam logic [4:0] POS_IDLE   = 5'd0;
    localparam logic [4:0] POS_LAST   = 5'd23;
    localparam logic [4:0] FOOTER_POS = 5'd24;

    localparam logic [3:0] LAST_CH = 4'd15;

    localparam logic [1:0] CFG_HEADER     = 2'd0;
    localparam logic [1:0] CFG_FOOTER     = 2'd1;
    localparam logic [1:0] CFG_ALT_NIBBLE = 2'd2;

    localparam logic [7:0] HEADER_RST     = 8'h0F;
    localparam logic [7:0] FOOTER_RST     = 8'h00;
    localparam logic [3:0] ALT_NIBBLE_RST = 4'h4;

    // one checked frame waiting to be unpacked
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [3:0]        flags;
        logic              ok;
    } frame_t;

endpackage

// ===== rtl/sfr_ifs.sv =====
// ----------------------------------------------------------------------------
// sfr_ifs
// Valid/ready channels for received bytes and unpacked channel results.
// ----------------------------------------------------------------------------
interface sfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic        digital_ch17;
    logic        digital_ch18;
    logic        frame_lost;
    logic        failsafe_active;
    logic        frame_ok;
    logic        last_of_frame;

    modport source (output valid, output channel_index, output channel_value,
                    output digital_ch17, output digital_ch18, output frame_lost,
                    output failsafe_active, output frame_ok, output last_of_frame,
                    input ready);
    modport sink   (input valid, input channel_index, input channel_value,
                    input digital_ch17, input digital_ch18, input frame_lost,
                    input failsafe_active, input frame_ok, input last_of_frame,
                    output ready);
endinterface

// ===== rtl/sfr_front.sv =====
// ----------------------------------------------------------------------------
// sfr_front
// Byte framer: header/footer detection, payload capture, frame hand-off.
// ----------------------------------------------------------------------------
module sfr_front
    import sfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_wdata,
    sfr_byte_if.sink     rx,
    input  logic         q_full,
    output logic         push,
    output frame_t       push_frame
);

    logic [7:0]         header_reg;
    logic [7:0]         footer_reg;
    logic [3:0]         alt_reg;
    logic [4:0]         pos_reg;
    logic [4:0]         pos_next;
    logic [7:0]         prev_reg;
    logic [STORE_W-1:0] store_reg;
    logic               accept;
    logic               shift_en;
    logic               byte_is_footer;
    logic               prev_is_footer;

    assign rx.ready = !q_full;
    assign accept   = rx.valid && rx.ready;

    assign byte_is_footer = (rx.rx_byte == footer_reg) || (rx.rx_byte[3:0] == alt_reg);
    assign prev_is_footer = (prev_reg == footer_reg) || (prev_reg[3:0] == alt_reg);

    always_comb
    begin
        pos_next = pos_reg;
        push     = 1'b0;
        shift_en = 1'b0;
        if (accept)
        begin
            if (pos_reg == POS_IDLE)
            begin
                if ((rx.rx_byte == header_reg) && prev_is_footer)
                begin
                    pos_next = 5'd1;
                end
            end
            else if (pos_reg <= POS_LAST)
            begin
                shift_en = 1'b1;
                pos_next = pos_reg + 5'd1;
            end
            else if (pos_reg == FOOTER_POS)
            begin
                pos_next = POS_IDLE;
                push     = byte_is_footer;
            end
            else
            begin
                pos_next = POS_IDLE;
            end
        end
    end

    // after 23 shifts byte 0 sits at the bottom, the flag byte at the top
    assign push_frame.data  = store_reg[DATA_W-1:0];
    assign push_frame.flags = store_reg[DATA_W+3:DATA_W];
    assign push_frame.ok    = (store_reg[10:0] != '0) && (store_reg[21:11] != '0)
                           && (store_reg[32:22] != '0) && (store_reg[43:33] != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RST;
            footer_reg <= FOOTER_RST;
            alt_reg    <= ALT_NIBBLE_RST;
            pos_reg    <= POS_IDLE;
            prev_reg   <= FOOTER_RST;
        end
        else
        begin
            pos_reg <= pos_next;
            if (accept)
            begin
                prev_reg <= rx.rx_byte;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HEADER:     header_reg <= cfg_wdata;
                    CFG_FOOTER:     footer_reg <= cfg_wdata;
                    CFG_ALT_NIBBLE: alt_reg    <= cfg_wdata[3:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            store_reg <= {rx.rx_byte, store_reg[STORE_W-1:8]};
        end
    end

endmodule

// ===== rtl/sfr_queue.sv =====
// ----------------------------------------------------------------------------
// sfr_queue
// Two-entry frame queue between the framer and the unpacker.
// ----------------------------------------------------------------------------
module sfr_queue
    import sfr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  frame_t push_frame,
    input  logic   pop,
    output frame_t head,
    output logic   empty,
    output logic   full
);

    frame_t     entries [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = entries[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

// ===== rtl/sfr_back.sv =====
// ----------------------------------------------------------------------------
// sfr_back
// Channel unpacker: emits sixteen results per queued frame, one per cycle while results are taken.
// ----------------------------------------------------------------------------
module sfr_back
    import sfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  frame_t      head,
    input  logic        empty,
    output logic        pop,
    sfr_result_if.source res
);

    logic [3:0]      ch_reg;
    logic            valid_reg;
    logic            load;
    logic [3:0]      index_reg;
    logic [CH_W-1:0] value_reg;
    logic [3:0]      flags_reg;
    logic            ok_reg;
    logic            last_reg;

    assign load = !empty && (!valid_reg || res.ready);
    assign pop  = load && (ch_reg == LAST_CH);

    assign res.valid           = valid_reg;
    assign res.channel_index   = index_reg;
    assign res.channel_value   = value_reg;
    assign res.digital_ch17    = flags_reg[0];
    assign res.digital_ch18    = flags_reg[1];
    assign res.frame_lost      = flags_reg[2];
    assign res.failsafe_active = flags_reg[3];
    assign res.frame_ok        = ok_reg;
    assign res.last_of_frame   = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg    <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                ch_reg    <= ch_reg + 4'd1;
                valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // channel k is bits 11k..11k+10 of the little-endian data string
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            index_reg <= ch_reg;
            value_reg <= head.data[CH_W*ch_reg +: CH_W];
            flags_reg <= head.flags;
            ok_reg    <= head.ok;
            last_reg  <= (ch_reg == LAST_CH);
        end
    end

endmodule

// ===== rtl/sbus_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// sbus_frame_receiver
// Byte-serial receiver for 25-byte sbus frames, unpacking sixteen channels.
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  ---------+-----------+------------------------------------------------
//  rx       | in        | one received byte per item
//  res      | out       | one unpacked channel per item, 16 per good frame
//  cfg      | in        | header, footer and alternate footer nibble writes
//
// a byte is taken every cycle while the frame queue has room; the queue holds
// two checked frames and fills only when results are not being taken.
// the unpacker emits one result per cycle while results are taken, 16 per frame, from the head
// of the queue into an output register.
// reset returns to idle with header 0x0f, footer 0x00, alternate nibble 0x4.
// ----------------------------------------------------------------------------
module sbus_frame_receiver
    import sfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_wdata,
    sfr_byte_if.sink     rx,
    sfr_result_if.source res
);

    logic   push;
    frame_t push_frame;
    logic   pop;
    frame_t head;
    logic   empty;
    logic   full;

    sfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .rx         (rx),
        .q_full     (full),
        .push       (push),
        .push_frame (push_frame)
    );

    sfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    sfr_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (empty),
        .pop   (pop),
        .res   (res)
    );

endmodule
